// ===== src/sclru_pkg.sv =====
package sclru_pkg;

   localparam int SLOTS_DEFAULT         = 8;
   localparam int SEGMENT_SHIFT_DEFAULT = 12;
   localparam int OFFSET_BITS_DEFAULT   = 32;

   // request codes
   typedef enum logic [1:0] {
      REQ_LOOKUP     = 2'd0,
      REQ_INVALIDATE = 2'd1,
      REQ_LOAD_FAIL  = 2'd2
   } req_code_type;

   // response status codes
   typedef enum logic [1:0] {
      RSP_HIT         = 2'd0,
      RSP_MISS        = 2'd1,
      RSP_INVALIDATED = 2'd2,
      RSP_CLEARED     = 2'd3
   } rsp_code_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] offset;
      logic [2:0]  slot;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  slot_index;
      logic [31:0] segment_base;
      logic        evicted_valid;
      logic [31:0] evicted_base;
   } rsp_item_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_COMPARE,
      CS_SCAN,
      CS_SCAN_END,
      CS_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic scan_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic any_empty;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/sclru_ctrl.sv =====
module sclru_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_kind,
   output logic                     req_ready,
   input  sclru_pkg::dp_status_type status,
   output sclru_pkg::ctrl_cmd_type  cmd
);

   sclru_pkg::ctrl_state_type state_ff;
   sclru_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sclru_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         sclru_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  sclru_pkg::REQ_LOOKUP:     state_in = sclru_pkg::CS_COMPARE;
                  sclru_pkg::REQ_INVALIDATE: state_in = sclru_pkg::CS_COMMIT;
                  sclru_pkg::REQ_LOAD_FAIL:  state_in = sclru_pkg::CS_COMMIT;
                  default:                   state_in = sclru_pkg::CS_IDLE;
               endcase
            end
         end
         sclru_pkg::CS_COMPARE: begin
            cmd.compare = 1'b1;
            if (status.hit || status.any_empty) begin
               state_in = sclru_pkg::CS_COMMIT;
            end else begin
               state_in = sclru_pkg::CS_SCAN;
            end
         end
         sclru_pkg::CS_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = sclru_pkg::CS_SCAN_END;
            end
         end
         sclru_pkg::CS_SCAN_END: begin
            state_in = sclru_pkg::CS_COMMIT;
         end
         sclru_pkg::CS_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = sclru_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = sclru_pkg::CS_IDLE;
         end
      endcase
   end

endmodule

// ===== src/sclru_datapath.sv =====
module sclru_datapath #(
   parameter int SLOTS         = sclru_pkg::SLOTS_DEFAULT,
   parameter int SEGMENT_SHIFT = sclru_pkg::SEGMENT_SHIFT_DEFAULT,
   parameter int OFFSET_BITS   = sclru_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sclru_pkg::req_item_type  req,
   input  sclru_pkg::ctrl_cmd_type  cmd,
   output sclru_pkg::dp_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sclru_pkg::rsp_item_type  rsp
);

   localparam int IW  = $clog2(SLOTS);
   localparam int EFF = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
   localparam int TW  = (EFF > SEGMENT_SHIFT) ? (EFF - SEGMENT_SHIFT) : 1;
   localparam logic [31:0] OFF_MASK = 32'((64'd1 << EFF) - 64'd1);
   localparam logic [31:0] SEG_MASK = ~32'((64'd1 << SEGMENT_SHIFT) - 64'd1);

   sclru_pkg::req_item_type req_ff;
   sclru_pkg::rsp_item_type rsp_ff;
   sclru_pkg::rsp_item_type rsp_in;
   logic                    rsp_valid_ff;

   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] known_ff;
   logic [TW-1:0]    tag_ff [SLOTS];
   logic [63:0]      stamp_mem [SLOTS];
   logic [63:0]      counter_ff;
   logic [63:0]      counter_in;

   logic [IW-1:0] victim_ff;
   logic          hit_ff;
   logic [IW-1:0] scan_ff;
   logic [IW-1:0] rd_idx_ff;
   logic [63:0]   rd_data_ff;
   logic          rd_known_ff;
   logic          rd_live_ff;
   logic [63:0]   min_ff;
   logic [63:0]   rd_val;

   logic [31:0]   base;
   logic [TW-1:0] tag_q;
   logic [SLOTS-1:0] match;
   logic [IW-1:0] hit_idx;
   logic [IW-1:0] empty_idx;
   logic          clr_in_range;
   logic [IW-1:0] clr_idx;

   assign base         = req_ff.offset & OFF_MASK & SEG_MASK;
   assign tag_q        = TW'(base >> SEGMENT_SHIFT);
   assign counter_in   = counter_ff + 64'd1;
   assign rd_val       = rd_known_ff ? rd_data_ff : 64'd0;
   assign clr_in_range = (int'(req_ff.slot) < SLOTS);
   assign clr_idx      = IW'(req_ff.slot);

   // parallel tag compare, lowest slot wins
   always_comb begin
      hit_idx   = '0;
      empty_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (tag_ff[i] == tag_q);
         if (match[i]) begin
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            empty_idx = IW'(i);
         end
      end
   end

   assign status.hit       = |match;
   assign status.any_empty = ~&valid_ff;
   assign status.scan_last = (scan_ff == IW'(SLOTS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in = '0;
      case (req_ff.req_type)
         sclru_pkg::REQ_LOOKUP: begin
            rsp_in.status       = hit_ff ? sclru_pkg::RSP_HIT : sclru_pkg::RSP_MISS;
            rsp_in.slot_index   = 3'(victim_ff);
            rsp_in.segment_base = base;
            if (!hit_ff && valid_ff[victim_ff]) begin
               rsp_in.evicted_valid = 1'b1;
               rsp_in.evicted_base  = 32'(64'(tag_ff[victim_ff]) << SEGMENT_SHIFT);
            end
         end
         sclru_pkg::REQ_INVALIDATE: begin
            rsp_in.status     = sclru_pkg::RSP_INVALIDATED;
            rsp_in.slot_index = req_ff.slot;
         end
         sclru_pkg::REQ_LOAD_FAIL: begin
            rsp_in.status     = sclru_pkg::RSP_CLEARED;
            rsp_in.slot_index = req_ff.slot;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         known_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rd_live_ff   <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan_step;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.commit) begin
            case (req_ff.req_type)
               sclru_pkg::REQ_LOOKUP: begin
                  counter_ff          <= counter_in;
                  known_ff[victim_ff] <= 1'b1;
                  valid_ff[victim_ff] <= 1'b1;
               end
               sclru_pkg::REQ_INVALIDATE: begin
                  valid_ff <= '0;
               end
               sclru_pkg::REQ_LOAD_FAIL: begin
                  if (clr_in_range) begin
                     valid_ff[clr_idx] <= 1'b0;
                     known_ff[clr_idx] <= 1'b0;
                  end
               end
               default: begin
                  counter_ff <= counter_ff;
               end
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (cmd.compare) begin
         hit_ff    <= |match;
         victim_ff <= (|match) ? hit_idx : empty_idx;
         scan_ff   <= '0;
      end
      if (cmd.scan_step) begin
         scan_ff   <= scan_ff + IW'(1);
         rd_idx_ff <= scan_ff;
         rd_known_ff <= known_ff[scan_ff];
      end
      // running oldest stamp, strict compare keeps the lowest slot
      if (rd_live_ff && ((rd_idx_ff == '0) || (rd_val < min_ff))) begin
         min_ff    <= rd_val;
         victim_ff <= rd_idx_ff;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         if (req_ff.req_type == sclru_pkg::REQ_LOOKUP && !hit_ff) begin
            tag_ff[victim_ff] <= tag_q;
         end
         if (req_ff.req_type == sclru_pkg::REQ_LOAD_FAIL && clr_in_range) begin
            tag_ff[clr_idx] <= '0;
         end
      end
   end

   // stamp memory, one write and one read port
   always_ff @(posedge clock) begin
      if (cmd.commit && req_ff.req_type == sclru_pkg::REQ_LOOKUP) begin
         stamp_mem[victim_ff] <= counter_in;
      end
      if (cmd.scan_step) begin
         rd_data_ff <= stamp_mem[scan_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== src/segment_cache_lru_lookup_top.sv =====
// tag and replacement store of a fully associative segment cache with lru victim
// choice. one request is worked on at a time; a request is taken only while the
// controller is idle, and its result sits in an output register so the next
// request may be taken while that result still waits. a lookup that hits, or that
// misses with an empty slot free, goes from the compare state to the commit state,
// which writes its result into the output register. a miss with every slot valid
// walks the stamp memory through its single read port, one slot a cycle, then
// passes the scan end state before the commit. invalidate and load-failure
// requests go straight to the commit state. a result still held by the receiver
// holds the next request at its final step until the output register frees. stamp
// memory entries that were never written, or whose slot was cleared, read as zero
// via per-slot known bits, so no clearing pass follows reset. request code 3 is
// taken and dropped with no result, and the controller stays idle.
module segment_cache_lru_lookup_top #(
   parameter int SLOTS         = sclru_pkg::SLOTS_DEFAULT,
   parameter int SEGMENT_SHIFT = sclru_pkg::SEGMENT_SHIFT_DEFAULT,
   parameter int OFFSET_BITS   = sclru_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sclru_pkg::req_item_type req,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sclru_pkg::rsp_item_type rsp
);

   // command and status between controller and datapath
   sclru_pkg::ctrl_cmd_type  cmd;
   sclru_pkg::dp_status_type status;

   sclru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // tag compare, victim scan, stamp memory and result register
   sclru_datapath #(
      .SLOTS         (SLOTS),
      .SEGMENT_SHIFT (SEGMENT_SHIFT),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // a lookup transfer keeps the block busy in the next cycle
   a_lookup_busy : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req.req_type == sclru_pkg::REQ_LOOKUP) |=> !req_ready)
      else $error("lookup transfer not followed by a busy cycle");

   // a miss never evicts the segment it is about to load
   a_evict_differs : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == sclru_pkg::RSP_MISS && rsp.evicted_valid)
         |-> (rsp.evicted_base != rsp.segment_base))
      else $error("evicted base equals the missed segment base");

   // a hit evicts nothing
   a_hit_no_evict : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == sclru_pkg::RSP_HIT)
         |-> (!rsp.evicted_valid && rsp.evicted_base == 32'd0))
      else $error("hit reports an eviction");

endmodule
